[design/bfsa_pkg.sv]
// Shared types and constants of the best-fit segment allocator.
// No dependencies; imported by every design file except bfsa_seg_ram.
`default_nettype none
package bfsa_pkg;

  localparam int LEN_W     = 17;
  localparam int ADDR_W    = 20;
  localparam int TOTAL_W   = 21;
  localparam int MAXC_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd2;

  localparam logic [LEN_W-1:0]  CHUNK_LEN_RST  = 17'd4096;
  localparam logic [MAXC_W-1:0] MAX_CHUNKS_RST = 5'd1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_ENABLED,
    ST_BAD_SIZE,
    ST_NO_FIT,
    ST_TABLE_FULL,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic {
    FUNC_ALLOC,
    FUNC_FREE
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CL,
    S_CL_WAIT,
    S_OPEN0,
    S_RQ,
    S_RQ_WAIT,
    S_SCAN_U,
    S_SCAN_F,
    S_DECIDE,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    func_t             func;
    logic [LEN_W-1:0]  req_length;
    logic [ADDR_W-1:0] req_address;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    status_t            status;
    logic [ADDR_W-1:0]  grant_address;
    logic [LEN_W-1:0]   grant_length;
    logic [TOTAL_W-1:0] free_total;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  chunk_len;
    logic [MAXC_W-1:0] max_chunks;
    logic              enabled;
  } cfg_t;

endpackage
`default_nettype wire

[design/bfsa_seg_ram.sv]
// Segment table storage: one write port, one read port, registered read data.
// Uses no package.
`default_nettype none
module bfsa_seg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/bfsa_round.sv]
// Rounds a length up to a multiple of the alignment by reciprocal multiplication; result and
// done are registered from start. Depends on bfsa_pkg for the length width.
`default_nettype none
module bfsa_round import bfsa_pkg::*; #(
  parameter int ALIGN_BYTES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [LEN_W-1:0] val,
  output logic                  done,
  output logic [LEN_W:0]        res
);

  // quotient = ((val + A - 1) * RECIP) >> SH, exact for every sum below 2**NW
  localparam int NW = LEN_W + 1;
  localparam int LG = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 0;
  localparam int SH = NW + LG;
  localparam int PW = NW + SH + 1;
  localparam logic [PW-1:0] RECIP    =
    PW'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [NW-1:0] ALIGN_N  = NW'(ALIGN_BYTES);
  localparam logic [NW-1:0] ALIGN_M1 = NW'(ALIGN_BYTES - 1);

  logic          done_r, done_nxt;
  logic [NW-1:0] res_r, res_nxt;
  logic [NW-1:0] sum;
  logic [PW-1:0] prod;
  logic [NW-1:0] quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    sum      = NW'(val) + ALIGN_M1;
    prod     = PW'(sum) * RECIP;
    quot     = prod[SH +: NW];
    done_nxt = start;
    res_nxt  = start ? quot * ALIGN_N : res_r;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

[design/bfsa_ctrl.sv]
// Allocator sequencer: scans the used and free tables, decides, writes back.
// Depends on bfsa_pkg, bfsa_seg_ram and bfsa_round.
`default_nettype none
module bfsa_ctrl import bfsa_pkg::*; #(
  parameter int MAX_CHUNKS   = 16,
  parameter int OFFSET_BITS  = 16,
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64,
  parameter int ALIGN_BYTES  = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire in_item_t  in_item,
  input  wire logic      in_take,
  output logic           idle,
  input  wire logic      out_free,
  output logic           res_valid,
  output out_item_t      res
);

  localparam int LW   = OFFSET_BITS + 1;
  localparam int CIW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW   = OFFSET_BITS + CIW;
  localparam int CHW  = $clog2(MAX_CHUNKS + 1);
  localparam int FIW  = $clog2(FREE_ENTRIES);
  localparam int UIW  = $clog2(USED_ENTRIES);
  localparam int PW   = ((FIW > UIW) ? FIW : UIW) + 1;
  localparam int EW   = AW + LW;
  localparam int CMPW = ((AW > ADDR_W) ? AW : ADDR_W) + 2;
  localparam int RW   = LEN_W + 1;
  localparam int MW   = ((RW > LW) ? RW : LW) + 1;
  localparam int EMW  = ((CHW > MAXC_W) ? CHW : MAXC_W) + 1;
  localparam int CAP  = ((1 << OFFSET_BITS) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [LW-1:0]    CAP_L   = LW'(CAP);
  localparam logic [LEN_W-1:0] ALIGN_L = LEN_W'(ALIGN_BYTES);
  localparam logic [PW-1:0]    U_END   = PW'(USED_ENTRIES);
  localparam logic [PW-1:0]    F_END   = PW'(FREE_ENTRIES);
  localparam logic [EMW-1:0]   MAXC_E  = EMW'(MAX_CHUNKS);

  ctrl_state_t state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [LEN_W-1:0]   req_len_r, req_len_nxt;
  logic [ADDR_W-1:0]  req_addr_r, req_addr_nxt;
  logic [LW-1:0]      ecl_r, ecl_nxt;
  logic [LW-1:0]      rl_r, rl_nxt;
  logic [CHW-1:0]     chunks_open_r, chunks_open_nxt;
  logic [TOTAL_W-1:0] free_bytes_r, free_bytes_nxt;
  logic [FREE_ENTRIES-1:0] fvalid_r, fvalid_nxt;
  logic [USED_ENTRIES-1:0] uvalid_r, uvalid_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic [PW-1:0]      idxd_r, idxd_nxt;
  logic               pend_r, pend_nxt;
  logic               u_found_r, u_found_nxt;
  logic [UIW-1:0]     u_idx_r, u_idx_nxt;
  logic [LW-1:0]      u_len_r, u_len_nxt;
  logic               fs_found_r, fs_found_nxt;
  logic [FIW-1:0]     fs_idx_r, fs_idx_nxt;
  logic               bf_found_r, bf_found_nxt;
  logic [FIW-1:0]     bf_idx_r, bf_idx_nxt;
  logic [LW-1:0]      bf_len_r, bf_len_nxt;
  logic [AW-1:0]      bf_addr_r, bf_addr_nxt;
  logic               p_found_r, p_found_nxt;
  logic [FIW-1:0]     p_idx_r, p_idx_nxt;
  logic [AW-1:0]      p_addr_r, p_addr_nxt;
  logic [LW-1:0]      p_len_r, p_len_nxt;
  logic               n_found_r, n_found_nxt;
  logic [FIW-1:0]     n_idx_r, n_idx_nxt;
  logic [LW-1:0]      n_len_r, n_len_nxt;
  status_t            status_r, status_nxt;
  logic [AW-1:0]      gaddr_r, gaddr_nxt;
  logic [LW-1:0]      glen_r, glen_nxt;

  logic           fw_en, uw_en;
  logic [FIW-1:0] fw_idx, fr_idx;
  logic [UIW-1:0] uw_idx, ur_idx;
  logic [EW-1:0]  fw_data, uw_data, fr_data, ur_data;
  logic [AW-1:0]  fr_addr, ur_addr, new_addr;
  logic [LW-1:0]  fr_len, ur_len;
  logic [CMPW-1:0] req_c, f_addr_c, f_end_c, u_end_c, gaddr_c;
  logic            same_chunk;
  logic [EMW-1:0]  emax;
  logic [FIW-1:0]  fi;
  logic [UIW-1:0]  ui;

  logic             rnd_start, rnd_done;
  logic [LEN_W-1:0] rnd_val;
  logic [RW-1:0]    rnd_res;

  bfsa_seg_ram #(.DEPTH(FREE_ENTRIES), .WIDTH(EW)) u_free_ram (
    .clk(clk), .we(fw_en), .waddr(fw_idx), .wdata(fw_data), .raddr(fr_idx), .rdata(fr_data)
  );

  bfsa_seg_ram #(.DEPTH(USED_ENTRIES), .WIDTH(EW)) u_used_ram (
    .clk(clk), .we(uw_en), .waddr(uw_idx), .wdata(uw_data), .raddr(ur_idx), .rdata(ur_data)
  );

  bfsa_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
    .clk(clk), .rst_n(rst_n), .start(rnd_start), .val(rnd_val), .done(rnd_done), .res(rnd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chunks_open_r <= '0;
      free_bytes_r  <= '0;
      fvalid_r      <= '0;
      uvalid_r      <= '0;
      pend_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chunks_open_r <= chunks_open_nxt;
      free_bytes_r  <= free_bytes_nxt;
      fvalid_r      <= fvalid_nxt;
      uvalid_r      <= uvalid_nxt;
      pend_r        <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    req_len_r  <= req_len_nxt;
    req_addr_r <= req_addr_nxt;
    ecl_r      <= ecl_nxt;
    rl_r       <= rl_nxt;
    ptr_r      <= ptr_nxt;
    idxd_r     <= idxd_nxt;
    u_found_r  <= u_found_nxt;
    u_idx_r    <= u_idx_nxt;
    u_len_r    <= u_len_nxt;
    fs_found_r <= fs_found_nxt;
    fs_idx_r   <= fs_idx_nxt;
    bf_found_r <= bf_found_nxt;
    bf_idx_r   <= bf_idx_nxt;
    bf_len_r   <= bf_len_nxt;
    bf_addr_r  <= bf_addr_nxt;
    p_found_r  <= p_found_nxt;
    p_idx_r    <= p_idx_nxt;
    p_addr_r   <= p_addr_nxt;
    p_len_r    <= p_len_nxt;
    n_found_r  <= n_found_nxt;
    n_idx_r    <= n_idx_nxt;
    n_len_r    <= n_len_nxt;
    status_r   <= status_nxt;
    gaddr_r    <= gaddr_nxt;
    glen_r     <= glen_nxt;
  end

  assign fr_addr  = fr_data[EW-1:LW];
  assign fr_len   = fr_data[LW-1:0];
  assign ur_addr  = ur_data[EW-1:LW];
  assign ur_len   = ur_data[LW-1:0];
  assign req_c    = CMPW'(req_addr_r);
  assign f_addr_c = CMPW'(fr_addr);
  assign f_end_c  = CMPW'(fr_addr) + CMPW'(fr_len);
  assign u_end_c  = req_c + CMPW'(u_len_r);
  assign same_chunk = (f_addr_c >> OFFSET_BITS) == (req_c >> OFFSET_BITS);
  assign new_addr = {chunks_open_r[CIW-1:0], {OFFSET_BITS{1'b0}}};
  assign fi       = idxd_r[FIW-1:0];
  assign ui       = idxd_r[UIW-1:0];
  assign emax     = (cfg.max_chunks == '0) ? EMW'(1)
                  : ((EMW'(cfg.max_chunks) > MAXC_E) ? MAXC_E : EMW'(cfg.max_chunks));

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    req_len_nxt     = req_len_r;
    req_addr_nxt    = req_addr_r;
    ecl_nxt         = ecl_r;
    rl_nxt          = rl_r;
    chunks_open_nxt = chunks_open_r;
    free_bytes_nxt  = free_bytes_r;
    fvalid_nxt      = fvalid_r;
    uvalid_nxt      = uvalid_r;
    ptr_nxt         = ptr_r;
    idxd_nxt        = idxd_r;
    pend_nxt        = 1'b0;
    u_found_nxt     = u_found_r;
    u_idx_nxt       = u_idx_r;
    u_len_nxt       = u_len_r;
    fs_found_nxt    = fs_found_r;
    fs_idx_nxt      = fs_idx_r;
    bf_found_nxt    = bf_found_r;
    bf_idx_nxt      = bf_idx_r;
    bf_len_nxt      = bf_len_r;
    bf_addr_nxt     = bf_addr_r;
    p_found_nxt     = p_found_r;
    p_idx_nxt       = p_idx_r;
    p_addr_nxt      = p_addr_r;
    p_len_nxt       = p_len_r;
    n_found_nxt     = n_found_r;
    n_idx_nxt       = n_idx_r;
    n_len_nxt       = n_len_r;
    status_nxt      = status_r;
    gaddr_nxt       = gaddr_r;
    glen_nxt        = glen_r;
    fw_en     = 1'b0;
    fw_idx    = '0;
    fw_data   = '0;
    uw_en     = 1'b0;
    uw_idx    = '0;
    uw_data   = '0;
    fr_idx    = ptr_r[FIW-1:0];
    ur_idx    = ptr_r[UIW-1:0];
    rnd_start = 1'b0;
    rnd_val   = req_len_r;
    res_valid = 1'b0;
    idle      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_take) begin
          func_nxt     = in_item.func;
          req_len_nxt  = in_item.req_length;
          req_addr_nxt = in_item.req_address;
          u_found_nxt  = 1'b0;
          fs_found_nxt = 1'b0;
          bf_found_nxt = 1'b0;
          p_found_nxt  = 1'b0;
          n_found_nxt  = 1'b0;
          status_nxt   = ST_OK;
          ptr_nxt      = '0;
          state_nxt    = S_CL;
        end
      end
      S_CL: begin
        rnd_start = 1'b1;
        rnd_val   = (cfg.chunk_len < ALIGN_L) ? ALIGN_L : cfg.chunk_len;
        state_nxt = S_CL_WAIT;
      end
      S_CL_WAIT: begin
        if (rnd_done) begin
          ecl_nxt   = (MW'(rnd_res) > MW'(CAP_L)) ? CAP_L : LW'(rnd_res);
          state_nxt = S_OPEN0;
        end
      end
      S_OPEN0: begin
        // tables are empty while no chunk is open, so chunk 0 takes slot 0
        if (cfg.enabled && chunks_open_r == '0) begin
          fw_en           = 1'b1;
          fw_idx          = '0;
          fw_data         = {{AW{1'b0}}, ecl_r};
          fvalid_nxt[0]   = 1'b1;
          chunks_open_nxt = CHW'(1);
          free_bytes_nxt  = free_bytes_r + TOTAL_W'(ecl_r);
        end
        if (func_r == FUNC_FREE) begin
          state_nxt = S_SCAN_U;
        end else if (!cfg.enabled) begin
          status_nxt = ST_NOT_ENABLED;
          state_nxt  = S_DONE;
        end else if (req_len_r == '0) begin
          status_nxt = ST_BAD_SIZE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_RQ;
        end
      end
      S_RQ: begin
        rnd_start = 1'b1;
        rnd_val   = req_len_r;
        state_nxt = S_RQ_WAIT;
      end
      S_RQ_WAIT: begin
        if (rnd_done) begin
          if (MW'(rnd_res) > MW'(ecl_r)) begin
            status_nxt = ST_BAD_SIZE;
            state_nxt  = S_DONE;
          end else begin
            rl_nxt    = LW'(rnd_res);
            state_nxt = S_SCAN_U;
          end
        end
      end
      S_SCAN_U: begin
        if (ptr_r != U_END) begin
          ptr_nxt  = ptr_r + PW'(1);
          idxd_nxt = ptr_r;
          pend_nxt = 1'b1;
        end
        if (pend_r && !u_found_r) begin
          if (func_r == FUNC_ALLOC) begin
            if (!uvalid_r[ui]) begin
              u_found_nxt = 1'b1;
              u_idx_nxt   = ui;
            end
          end else if (uvalid_r[ui] && CMPW'(ur_addr) == req_c) begin
            u_found_nxt = 1'b1;
            u_idx_nxt   = ui;
            u_len_nxt   = ur_len;
          end
        end
        if (ptr_r == U_END && !pend_r) begin
          ptr_nxt = '0;
          if (!u_found_r) begin
            status_nxt = (func_r == FUNC_ALLOC) ? ST_TABLE_FULL : ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN_F;
          end
        end
      end
      S_SCAN_F: begin
        if (ptr_r != F_END) begin
          ptr_nxt  = ptr_r + PW'(1);
          idxd_nxt = ptr_r;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (!fvalid_r[fi] && !fs_found_r) begin
            fs_found_nxt = 1'b1;
            fs_idx_nxt   = fi;
          end
          if (func_r == FUNC_ALLOC) begin
            if (fvalid_r[fi] && fr_len >= rl_r &&
                (!bf_found_r || fr_len < bf_len_r ||
                 (fr_len == bf_len_r && fr_addr < bf_addr_r))) begin
              bf_found_nxt = 1'b1;
              bf_idx_nxt   = fi;
              bf_len_nxt   = fr_len;
              bf_addr_nxt  = fr_addr;
            end
          end else if (fvalid_r[fi] && same_chunk) begin
            // last touching neighbour in table order wins
            if (f_end_c == req_c) begin
              p_found_nxt = 1'b1;
              p_idx_nxt   = fi;
              p_addr_nxt  = fr_addr;
              p_len_nxt   = fr_len;
            end
            if (f_addr_c == u_end_c) begin
              n_found_nxt = 1'b1;
              n_idx_nxt   = fi;
              n_len_nxt   = fr_len;
            end
          end
        end
        if (ptr_r == F_END && !pend_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (func_r == FUNC_ALLOC) begin
          if (bf_found_r) begin
            gaddr_nxt = bf_addr_r;
            if (bf_len_r == rl_r) begin
              fvalid_nxt[bf_idx_r] = 1'b0;
            end else begin
              fw_en   = 1'b1;
              fw_idx  = bf_idx_r;
              fw_data = {bf_addr_r + AW'(rl_r), bf_len_r - rl_r};
            end
            free_bytes_nxt = free_bytes_r - TOTAL_W'(rl_r);
          end else if (EMW'(chunks_open_r) >= emax) begin
            status_nxt = ST_NO_FIT;
          end else if (!fs_found_r) begin
            status_nxt = ST_TABLE_FULL;
          end else begin
            // fresh chunk, allocated from its start
            gaddr_nxt = new_addr;
            if (ecl_r != rl_r) begin
              fw_en                = 1'b1;
              fw_idx               = fs_idx_r;
              fw_data              = {new_addr + AW'(rl_r), ecl_r - rl_r};
              fvalid_nxt[fs_idx_r] = 1'b1;
            end
            chunks_open_nxt = chunks_open_r + CHW'(1);
            free_bytes_nxt  = free_bytes_r + TOTAL_W'(ecl_r) - TOTAL_W'(rl_r);
          end
          if (bf_found_r || (EMW'(chunks_open_r) < emax && fs_found_r)) begin
            uw_en              = 1'b1;
            uw_idx             = u_idx_r;
            uw_data            = {(bf_found_r ? bf_addr_r : new_addr), rl_r};
            uvalid_nxt[u_idx_r] = 1'b1;
            glen_nxt           = rl_r;
          end
        end else begin
          if (p_found_r && n_found_r) begin
            fw_en               = 1'b1;
            fw_idx              = p_idx_r;
            fw_data             = {p_addr_r, p_len_r + u_len_r + n_len_r};
            fvalid_nxt[n_idx_r] = 1'b0;
          end else if (p_found_r) begin
            fw_en   = 1'b1;
            fw_idx  = p_idx_r;
            fw_data = {p_addr_r, p_len_r + u_len_r};
          end else if (n_found_r) begin
            fw_en   = 1'b1;
            fw_idx  = n_idx_r;
            fw_data = {AW'(req_addr_r), n_len_r + u_len_r};
          end else if (fs_found_r) begin
            fw_en                = 1'b1;
            fw_idx               = fs_idx_r;
            fw_data              = {AW'(req_addr_r), u_len_r};
            fvalid_nxt[fs_idx_r] = 1'b1;
          end else begin
            status_nxt = ST_TABLE_FULL;
          end
          if (p_found_r || n_found_r || fs_found_r) begin
            uvalid_nxt[u_idx_r] = 1'b0;
            free_bytes_nxt      = free_bytes_r + TOTAL_W'(u_len_r);
            glen_nxt            = u_len_r;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign gaddr_c = CMPW'(gaddr_r);

  always_comb begin
    res.ok            = (status_r == ST_OK);
    res.status        = status_r;
    res.grant_address = (status_r == ST_OK && func_r == FUNC_ALLOC) ? gaddr_c[ADDR_W-1:0] : '0;
    res.grant_length  = (status_r == ST_OK) ? LEN_W'(glen_r) : '0;
    res.free_total    = free_bytes_r;
  end

endmodule
`default_nettype wire

[design/best_fit_segment_allocator.sv]
// Best-fit segment allocator: configuration registers, result register, sequencer.
// Depends on bfsa_pkg and bfsa_ctrl.
// Allocate and free scan the used table and then the free table entry by entry; rejected
// sizes skip both scans. One operation at a time; a stalled result holds the next one in
// the sequencer. Reset clears all table valid bits at once.
`default_nettype none
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int MAX_CHUNKS   = 16,
  parameter int OFFSET_BITS  = 16,
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64,
  parameter int ALIGN_BYTES  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      idle, res_valid, out_free;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign out_free  = !out_valid_r || !out_stall;

  bfsa_ctrl #(
    .MAX_CHUNKS(MAX_CHUNKS), .OFFSET_BITS(OFFSET_BITS), .FREE_ENTRIES(FREE_ENTRIES),
    .USED_ENTRIES(USED_ENTRIES), .ALIGN_BYTES(ALIGN_BYTES)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_item(in_data), .in_take(in_valid && idle),
    .idle(idle), .out_free(out_free), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{chunk_len: CHUNK_LEN_RST, max_chunks: MAX_CHUNKS_RST, enabled: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHUNK_LEN:  cfg_nxt.chunk_len  = cfg_data;
        CFG_MAX_CHUNKS: cfg_nxt.max_chunks = cfg_data[MAXC_W-1:0];
        CFG_ENABLED:    cfg_nxt.enabled    = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[design/bfsa_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on bfsa_pkg and best_fit_segment_allocator.
`default_nettype none
module bfsa_checker import bfsa_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ok == (out_data.status == ST_OK))
    else $error("ok flag disagrees with status");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.grant_address == '0 && out_data.grant_length == '0)
    else $error("failed operation carries a grant");

  // the sequencer leaves idle on a transfer, so the input stalls right after it
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while busy");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

[test/tb_top.sv]
// Testbench for best_fit_segment_allocator: directed and random allocate/free traffic,
// checked against a behavioural copy of both segment tables. Depends on bfsa_pkg.
`timescale 1ns / 1ps
module tb_top;
  import bfsa_pkg::*;

  localparam int NFREE = 64;
  localparam int NUSED = 64;
  localparam int CHUNKS = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit          v;
    int unsigned base;
    int unsigned len;
  } span_t;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CHUNK_LEN;
  logic [LEN_W-1:0]     cfg_data = '0;

  best_fit_segment_allocator u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // allocator state as the block should hold it
  span_t       free_tab [NFREE];
  span_t       used_tab [NUSED];
  int unsigned chunks_open;
  int unsigned bytes_free;
  int unsigned chunk_len_r = CHUNK_LEN_RST;
  int unsigned max_chunks_r = MAX_CHUNKS_RST;
  bit          enabled_r = 0;

  out_item_t   pending_results [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.ok !== want.ok) begin
          $error("ok: expected %0d got %0d", want.ok, out_data.ok);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.grant_address !== want.grant_address) begin
          $error("grant_address: expected %h got %h", want.grant_address,
                 out_data.grant_address);
          errors++;
        end
        if (out_data.grant_length !== want.grant_length) begin
          $error("grant_length: expected %0d got %0d", want.grant_length,
                 out_data.grant_length);
          errors++;
        end
        if (out_data.free_total !== want.free_total) begin
          $error("free_total: expected %0d got %0d", want.free_total, out_data.free_total);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned eff_chunk_len();
    int unsigned x;
    x = chunk_len_r;
    if (x < 8) x = 8;
    x = ((x + 7) / 8) * 8;
    if (x > 65536) x = 65536;
    return x;
  endfunction

  function automatic int unsigned eff_max_chunks();
    int unsigned m;
    m = max_chunks_r;
    if (m < 1) m = 1;
    if (m > CHUNKS) m = CHUNKS;
    return m;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < NFREE; i++) if (!free_tab[i].v) return i;
    return -1;
  endfunction

  function automatic bit open_chunk();
    int s;
    s = first_free_slot();
    if (s < 0) return 0;
    free_tab[s] = '{1'b1, chunks_open << 16, eff_chunk_len()};
    chunks_open++;
    bytes_free = (bytes_free + eff_chunk_len()) & 32'h1F_FFFF;
    return 1;
  endfunction

  function automatic int best_fit(int unsigned r);
    int b;
    b = -1;
    for (int i = 0; i < NFREE; i++) begin
      if (!free_tab[i].v || free_tab[i].len < r) continue;
      if (b < 0 || free_tab[i].len < free_tab[b].len ||
          (free_tab[i].len == free_tab[b].len && free_tab[i].base < free_tab[b].base))
        b = i;
    end
    return b;
  endfunction

  function automatic status_t alloc_span(int unsigned req, output int unsigned base,
                                         output int unsigned glen);
    int unsigned r;
    int u;
    int b;
    base = 0;
    glen = 0;
    if (!enabled_r) return ST_NOT_ENABLED;
    if (req == 0) return ST_BAD_SIZE;
    r = ((req + 7) / 8) * 8;
    if (r > eff_chunk_len()) return ST_BAD_SIZE;
    u = -1;
    for (int i = NUSED - 1; i >= 0; i--) if (!used_tab[i].v) u = i;
    if (u < 0) return ST_TABLE_FULL;
    b = best_fit(r);
    if (b < 0) begin
      if (chunks_open >= eff_max_chunks()) return ST_NO_FIT;
      if (!open_chunk()) return ST_TABLE_FULL;
      b = best_fit(r);
      if (b < 0) return ST_NO_FIT;
    end
    base = free_tab[b].base;
    if (free_tab[b].len == r) free_tab[b].v = 0;
    else begin
      free_tab[b].base += r;
      free_tab[b].len -= r;
    end
    used_tab[u] = '{1'b1, base, r};
    bytes_free = (bytes_free - r) & 32'h1F_FFFF;
    glen = r;
    return ST_OK;
  endfunction

  function automatic status_t release_span(int unsigned base, output int unsigned glen);
    int u;
    int prev;
    int nxt;
    int s;
    int unsigned len;
    int unsigned stop;
    u = -1;
    prev = -1;
    nxt = -1;
    glen = 0;
    for (int i = NUSED - 1; i >= 0; i--)
      if (used_tab[i].v && used_tab[i].base == base) u = i;
    if (u < 0) return ST_NOT_FOUND;
    len = used_tab[u].len;
    stop = base + len;
    for (int i = 0; i < NFREE; i++) begin
      if (!free_tab[i].v || (free_tab[i].base >> 16) != (base >> 16)) continue;
      if (free_tab[i].base + free_tab[i].len == base) prev = i;
      if (free_tab[i].base == stop) nxt = i;
    end
    if (prev >= 0 && nxt >= 0) begin
      free_tab[prev].len += len + free_tab[nxt].len;
      free_tab[nxt].v = 0;
    end else if (prev >= 0) begin
      free_tab[prev].len += len;
    end else if (nxt >= 0) begin
      free_tab[nxt].base = base;
      free_tab[nxt].len += len;
    end else begin
      s = first_free_slot();
      if (s < 0) return ST_TABLE_FULL;
      free_tab[s] = '{1'b1, base, len};
    end
    used_tab[u].v = 0;
    bytes_free = (bytes_free + len) & 32'h1F_FFFF;
    glen = len;
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    status_t st;
    int unsigned base;
    int unsigned glen;
    if (enabled_r && chunks_open == 0) void'(open_chunk());
    if (it.func == FUNC_ALLOC) st = alloc_span(it.req_length, base, glen);
    else begin
      st = release_span(it.req_address, glen);
      base = 0;
    end
    res.ok = (st == ST_OK);
    res.status = st;
    res.grant_address = (st == ST_OK) ? base[ADDR_W-1:0] : '0;
    res.grant_length = (st == ST_OK) ? glen[LEN_W-1:0] : '0;
    res.free_total = bytes_free[TOTAL_W-1:0];
    return res;
  endfunction

  task automatic send_item(func_t f, int unsigned len, int unsigned addr);
    in_item_t it;
    out_item_t want;
    it.func = f;
    it.req_length = len[LEN_W-1:0];
    it.req_address = addr[ADDR_W-1:0];
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    want = predict_result(it);
    pending_results = {pending_results, want};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // lower valid in the same step as the last transfer, then let the results drain
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHUNK_LEN:  chunk_len_r = value & 32'h1FFFF;
      CFG_MAX_CHUNKS: max_chunks_r = value & 32'h1F;
      CFG_ENABLED:    enabled_r = value & 1;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic free_some_used();
    int idx [$];
    for (int i = 0; i < NUSED; i++) if (used_tab[i].v) idx = {idx, i};
    if (idx.size() == 0) send_item(FUNC_FREE, $urandom, $urandom);
    else send_item(FUNC_FREE, $urandom, used_tab[idx[$urandom_range(idx.size() - 1)]].base);
  endtask

  task automatic test_disabled();
    send_item(FUNC_ALLOC, 16, 0);
    send_item(FUNC_FREE, 0, 20'hFFFFF);
    wait_drained();
  endtask

  task automatic test_directed();
    write_reg(CFG_CHUNK_LEN, 64);
    write_reg(CFG_MAX_CHUNKS, 2);
    write_reg(CFG_ENABLED, 1);
    send_item(FUNC_FREE, 0, 0);           // opens chunk 0, nothing to free
    send_item(FUNC_ALLOC, 0, 0);          // zero length
    send_item(FUNC_ALLOC, 65, 0);         // rounds past the chunk
    send_item(FUNC_ALLOC, 65536, 0);
    send_item(FUNC_ALLOC, 1, 20'hFFFFF);  // rounded to 8
    send_item(FUNC_ALLOC, 56, 0);         // exact fit of the rest
    send_item(FUNC_ALLOC, 16, 0);         // opens chunk 1
    send_item(FUNC_ALLOC, 48, 0);
    send_item(FUNC_ALLOC, 8, 0);          // all chunks open, no fit
    send_item(FUNC_FREE, 0, 20'h10008);   // not a segment start
    send_item(FUNC_FREE, 17'h1FFFF, 20'h10000);
    send_item(FUNC_FREE, 0, 20'h10010);   // merges with the lower neighbour
    send_item(FUNC_FREE, 0, 20'h00000);
    send_item(FUNC_FREE, 0, 20'h00008);   // merges with the lower neighbour
    send_item(FUNC_ALLOC, 64, 0);
    send_item(FUNC_FREE, 0, 20'h00000);
    wait_drained();
  endtask

  task automatic test_table_full();
    write_reg(CFG_CHUNK_LEN, 4096);
    write_reg(CFG_MAX_CHUNKS, 1);
    for (int i = 0; i < 70; i++) send_item(FUNC_ALLOC, $urandom_range(1, 8), $urandom);
    for (int i = 0; i < 64; i += 2) free_some_used();
    wait_drained();
  endtask

  task automatic test_random(int n, bit hold_off);
    int unsigned lim;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (hold_off && i == n / 2) wait_drained();
      lim = eff_chunk_len();
      if (lim > 512 && $urandom_range(9) != 0) lim = 512;
      pick = $urandom_range(99);
      if (pick < 48) send_item(FUNC_ALLOC, $urandom_range(1, lim), $urandom);
      else if (pick < 90) free_some_used();
      else if (pick < 95) send_item(FUNC_ALLOC, $urandom_range(0, 17'h1FFFF), $urandom);
      else send_item(FUNC_FREE, $urandom, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_table_full();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      write_reg(CFG_CHUNK_LEN, (ph == 0) ? 65536 : (ph == 1) ? 8 : $urandom_range(8, 8192));
      write_reg(CFG_MAX_CHUNKS, (ph == 0) ? 0 : (ph == 1) ? 31 : $urandom_range(1, 16));
      write_reg(CFG_ENABLED, 1);
      test_random(200, ph == 2);
      write_reg(CFG_ENABLED, ph[0]);
      write_reg(CFG_MAX_CHUNKS, 16);
      test_random(20, 0);
      write_reg(CFG_ENABLED, 1);
      write_reg(CFG_CHUNK_LEN, $urandom_range(256, 2048));
      test_random(200, 0);
    end
    stall_pct = 0;
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[best_fit_segment_allocator.f]
design/bfsa_pkg.sv
design/bfsa_seg_ram.sv
design/bfsa_round.sv
design/bfsa_ctrl.sv
design/best_fit_segment_allocator.sv
design/bfsa_checker.sv
test/tb_top.sv
